@@ rtl/rdvc_pkg.sv @@
// shared widths, defaults and codes for the range distinct value counter
package rdvc_pkg;

    localparam int LEAVES_DEFAULT      = 1024;
    localparam int VALUE_LIMIT_DEFAULT = 64;

    localparam int POS_W   = 11;
    localparam int VAL_W   = 6;
    localparam int COUNT_W = 7;

    // popcount works on groups of this many bits
    localparam int GROUP_W     = 8;
    localparam int GROUP_CNT_W = $clog2(GROUP_W + 1);

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

endpackage

@@ rtl/rdvc_ram.sv @@
// generic single-write, single-read ram with registered read data
module rdvc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rdvc_popcount.sv @@
// two-stage pipelined popcount of a presence mask
module rdvc_popcount #(
    parameter int WIDTH = rdvc_pkg::VALUE_LIMIT_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [WIDTH-1:0]             mask,
    output logic                         out_valid,
    output logic [rdvc_pkg::COUNT_W-1:0] count
);

    localparam int GROUPS = (WIDTH + rdvc_pkg::GROUP_W - 1) / rdvc_pkg::GROUP_W;
    localparam int PAD_W  = GROUPS * rdvc_pkg::GROUP_W;

    logic [PAD_W-1:0]                   padded;
    logic [rdvc_pkg::GROUP_CNT_W-1:0]   grp_next [GROUPS];
    logic [rdvc_pkg::GROUP_CNT_W-1:0]   grp_reg  [GROUPS];
    logic                               s1_valid_reg;
    logic                               s2_valid_reg;
    logic [rdvc_pkg::COUNT_W-1:0]       count_next;
    logic [rdvc_pkg::COUNT_W-1:0]       count_reg;

    assign padded = PAD_W'(mask);

    // per-group bit counts
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int i = 0; i < rdvc_pkg::GROUP_W; i++)
            begin
                grp_next[g] = grp_next[g]
                    + rdvc_pkg::GROUP_CNT_W'(padded[g * rdvc_pkg::GROUP_W + i]);
            end
        end
    end

    // sum of the group counts
    always_comb
    begin
        count_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            count_next = count_next + rdvc_pkg::COUNT_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        count_reg <= count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign count     = count_reg;

endmodule

@@ rtl/range_distinct_value_counter.sv @@
// top level: segment tree of presence masks in one ram, point write and range distinct count
// write item: leaf write, then one parent write per level up to the root, no result beat
// query item: left and right bound steps up the tree, then the popcount, one beat on done at the end
// span is LEAVES rounded up to a power of two, at least 2; both walks are set by the single ram read port
// after reset the ram is swept to zero, all 2*span words, with busy high
// done lasts one cycle and cannot be held off by the receiver
module range_distinct_value_counter #(
    parameter int LEAVES      = rdvc_pkg::LEAVES_DEFAULT,
    parameter int VALUE_LIMIT = rdvc_pkg::VALUE_LIMIT_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [rdvc_pkg::POS_W-1:0]   position,
    input  logic [rdvc_pkg::VAL_W-1:0]   new_value,
    input  logic [rdvc_pkg::POS_W-1:0]   left,
    input  logic [rdvc_pkg::POS_W-1:0]   right,
    output logic                         done,
    output logic [rdvc_pkg::COUNT_W-1:0] distinct_count
);

    // tree geometry: node 1 is the root, leaves start at SPAN
    localparam int LOG_SPAN = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
    localparam int SPAN     = 1 << LOG_SPAN;
    localparam int DEPTH    = 2 * SPAN;
    localparam int NW       = LOG_SPAN + 1;     // ram address bits
    localparam int IW       = NW + 1;           // walk bounds reach 2*SPAN
    localparam int MW       = VALUE_LIMIT;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_WR_LEAF = 3'd2;
    localparam logic [2:0] ST_WR_UP   = 3'd3;
    localparam logic [2:0] ST_Q_A     = 3'd4;
    localparam logic [2:0] ST_Q_B     = 3'd5;
    localparam logic [2:0] ST_Q_CNT   = 3'd6;
    localparam logic [2:0] ST_Q_WAIT  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic [NW-1:0] node_reg, node_next;
    logic [MW-1:0] cur_reg, cur_next;
    logic [IW-1:0] a_reg, a_next;
    logic [IW-1:0] b_reg, b_next;
    logic [MW-1:0] acc_reg, acc_next;
    logic          pend_reg, pend_next;

    // ram port signals
    logic          ram_we;
    logic [NW-1:0] ram_waddr;
    logic [MW-1:0] ram_wdata;
    logic [NW-1:0] ram_raddr;
    logic [MW-1:0] ram_rdata;

    logic          pc_in_valid;
    logic          pc_out_valid;

    // input decode
    logic          accept;
    logic          wr_ok;
    logic [31:0]   lo;
    logic [31:0]   hi;
    logic [MW-1:0] parent_mask;
    logic [NW-1:0] parent;
    logic [IW-1:0] b_dec;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // bad position or bad value makes the write a no-op
    assign wr_ok = (position != '0) && (32'(position) <= LEAVES)
                   && (32'(new_value) < VALUE_LIMIT);

    // clip the query range to the valid positions
    assign lo = (left == '0) ? 32'd1 : 32'(left);
    assign hi = (32'(right) > LEAVES) ? 32'(LEAVES) : 32'(right);

    assign parent_mask = cur_reg | ram_rdata;
    assign parent      = node_reg >> 1;
    assign b_dec       = b_reg[0] ? (b_reg - IW'(1)) : b_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        node_next   = node_reg;
        cur_next    = cur_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        pend_next   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = node_reg;
        ram_wdata   = cur_reg;
        ram_raddr   = node_reg ^ NW'(1);
        pc_in_valid = 1'b0;

        // fold in the mask read on the previous cycle
        acc_next = pend_reg ? (acc_reg | ram_rdata) : acc_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + NW'(1);
                if (clr_reg == NW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == rdvc_pkg::ACTION_WRITE)
                    begin
                        if (wr_ok)
                        begin
                            node_next  = NW'(SPAN) + NW'(position) - NW'(1);
                            cur_next   = MW'(1) << new_value;
                            state_next = ST_WR_LEAF;
                        end
                    end
                    else
                    begin
                        acc_next = '0;
                        if (lo <= hi)
                        begin
                            a_next = IW'(SPAN) + IW'(lo) - IW'(1);
                            b_next = IW'(SPAN) + IW'(hi);
                        end
                        else
                        begin
                            a_next = '0;
                            b_next = '0;
                        end
                        state_next = ST_Q_A;
                    end
                end
            end
            ST_WR_LEAF:
            begin
                // leaf written now, its sibling read for the first parent
                ram_we     = 1'b1;
                state_next = ST_WR_UP;
            end
            ST_WR_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = parent_mask;
                ram_raddr = parent ^ NW'(1);
                node_next = parent;
                cur_next  = parent_mask;
                if (parent == NW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_A:
            begin
                if (a_reg >= b_reg)
                begin
                    state_next = ST_Q_CNT;
                end
                else
                begin
                    // left bound is a right child: take it and step past it
                    if (a_reg[0])
                    begin
                        ram_raddr = a_reg[NW-1:0];
                        pend_next = 1'b1;
                        a_next    = a_reg + IW'(1);
                    end
                    state_next = ST_Q_B;
                end
            end
            ST_Q_B:
            begin
                // right bound odd: its left neighbor is covered
                if (b_reg[0])
                begin
                    ram_raddr = b_dec[NW-1:0];
                    pend_next = 1'b1;
                end
                a_next     = a_reg >> 1;
                b_next     = b_dec >> 1;
                state_next = ST_Q_A;
            end
            ST_Q_CNT:
            begin
                pc_in_valid = 1'b1;
                state_next  = ST_Q_WAIT;
            end
            ST_Q_WAIT:
            begin
                if (pc_out_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
        end
    end

    // walk registers carry payload only
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cur_reg  <= cur_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
    end

    rdvc_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rdvc_popcount #(
        .WIDTH (MW)
    ) u_popcount (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pc_in_valid),
        .mask      (acc_reg),
        .out_valid (pc_out_valid),
        .count     (distinct_count)
    );

    // result beat comes straight from the popcount output stage
    assign done = pc_out_valid;

endmodule
